// File: sv/pbdi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbdi_pkg
// Shared types, register indexes and the step microcode for the planar body
// drag integrator.
// ----------------------------------------------------------------------------
package pbdi_pkg;

  localparam int WORD_W = 32;
  localparam int DT_W   = 16;
  localparam int SEQ_W  = 5;
  localparam int SEQ_LEN = 17;
  localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(SEQ_LEN - 1);
  localparam logic [WORD_W-1:0] MAG_CAP = {1'b1, {(WORD_W-1){1'b0}}};

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [WORD_W-1:0]        mag_t;

  typedef enum logic [1:0] {
    MODE_STEP     = 2'd0,
    MODE_LOAD_POS = 2'd1,
    MODE_LOAD_VEL = 2'd2,
    MODE_LOAD_ROT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_DRAG      = 2'd0,
    CFG_SPIN_DRAG = 2'd1,
    CFG_INV_MASS  = 2'd2,
    CFG_INV_INERT = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_WB,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_ROT
  } axis_t;

  typedef enum logic {
    ASEL_VEL,
    ASEL_TMP
  } asel_t;

  typedef enum logic [1:0] {
    BSEL_VEL,
    BSEL_COEF,
    BSEL_INV,
    BSEL_DT
  } bsel_t;

  typedef enum logic [1:0] {
    DST_TMP,
    DST_POS,
    DST_VEL
  } dst_t;

  typedef struct packed {
    axis_t axis;
    asel_t asel;
    bsel_t bsel;
    logic  half;
    dst_t  dst;
  } uop_t;

  // Translational axis: v*v, *drag, *inv_mass, half-step pos, vel, half-step pos.
  // Rotation skips the square and starts from |spin| * spin drag.
  function automatic uop_t uop_at(input logic [SEQ_W-1:0] idx);
    uop_t       u;
    logic [2:0] k;
    if (idx < SEQ_W'(6)) begin
      u.axis = AXIS_X;
      k      = idx[2:0];
    end else if (idx < SEQ_W'(12)) begin
      u.axis = AXIS_Y;
      k      = 3'(idx - SEQ_W'(6));
    end else begin
      u.axis = AXIS_ROT;
      k      = 3'(idx - SEQ_W'(11));
    end
    case (k)
      3'd1: begin
        u.asel = (u.axis == AXIS_ROT) ? ASEL_VEL : ASEL_TMP;
        u.bsel = BSEL_COEF;
        u.half = 1'b0;
        u.dst  = DST_TMP;
      end
      3'd2: begin
        u.asel = ASEL_TMP;
        u.bsel = BSEL_INV;
        u.half = 1'b0;
        u.dst  = DST_TMP;
      end
      3'd3, 3'd5: begin
        u.asel = ASEL_VEL;
        u.bsel = BSEL_DT;
        u.half = 1'b1;
        u.dst  = DST_POS;
      end
      3'd4: begin
        u.asel = ASEL_TMP;
        u.bsel = BSEL_DT;
        u.half = 1'b0;
        u.dst  = DST_VEL;
      end
      default: begin
        u.asel = ASEL_VEL;
        u.bsel = BSEL_VEL;
        u.half = 1'b0;
        u.dst  = DST_TMP;
      end
    endcase
    return u;
  endfunction

endpackage

// File: sv/pbdi_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbdi_mul
// Shared magnitude multiplier: (a*b) >> 16 or 17, clamped to 2^31, registered.
// ----------------------------------------------------------------------------
module pbdi_mul (
  input  logic                 clk,
  input  logic                 en,
  input  pbdi_pkg::mag_t       op_a,
  input  pbdi_pkg::mag_t       op_b,
  input  logic                 half,
  output pbdi_pkg::mag_t       prod_r
);
  import pbdi_pkg::*;

  logic [2*WORD_W-1:0] full;
  logic [2*WORD_W-17:0] shifted;
  mag_t                 prod_nxt;

  always_comb begin
    full     = {{WORD_W{1'b0}}, op_a} * {{WORD_W{1'b0}}, op_b};
    shifted  = half ? {1'b0, full[2*WORD_W-1:17]} : full[2*WORD_W-1:16];
    prod_nxt = (shifted > (2*WORD_W-16)'(MAG_CAP)) ? MAG_CAP : shifted[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// File: sv/pbdi_sat_add.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbdi_sat_add
// Signed accumulate of a signed magnitude, saturated to 32-bit two's complement.
// ----------------------------------------------------------------------------
module pbdi_sat_add (
  input  pbdi_pkg::word_t old_val,
  input  logic            neg,
  input  pbdi_pkg::mag_t  mag,
  output pbdi_pkg::word_t sum
);
  import pbdi_pkg::*;

  logic signed [WORD_W+1:0] ext_old;
  logic signed [WORD_W+1:0] ext_mag;
  logic signed [WORD_W+1:0] total;

  always_comb begin
    ext_old = {{2{old_val[WORD_W-1]}}, old_val};
    ext_mag = {2'b00, mag};
    total   = neg ? (ext_old - ext_mag) : (ext_old + ext_mag);
    if (total > (WORD_W+2)'($signed({1'b0, {(WORD_W-1){1'b1}}}))) begin
      sum = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (total < -(WORD_W+2)'($signed({2'b00, MAG_CAP}))) begin
      sum = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      sum = total[WORD_W-1:0];
    end
  end

endmodule

// File: sv/planar_body_drag_integrator.sv
`timescale 1ns / 1ps
// A load transaction goes from accept straight to the DONE state; a step runs 17
//   multiply/write-back pairs through one shared multiplier before DONE.
// One item is processed at a time: in_tready is low while an item is in work,
//   and a pending result does not block new input.
// Reset (rst_n low, synchronous): state zero, drag 0, inv_mass/inv_inertia 1.0.
// ----------------------------------------------------------------------------
// planar_body_drag_integrator
// Planar rigid body midpoint integrator with quadratic drag and linear spin
// drag in Q16.16, sequenced over a shared multiplier and saturating adder.
// ----------------------------------------------------------------------------
module planar_body_drag_integrator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,   // dt[15:0], value_a[47:16], value_b[79:48]
  input  logic [1:0]   in_tuser,   // mode[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,  // pos_x, pos_y, vel_x, vel_y, angle, spin (32 each)
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import pbdi_pkg::*;

  state_t state_r, state_nxt;
  logic [SEQ_W-1:0] seq_r;
  logic [DT_W-1:0]  dt_r;
  mag_t             tmp_r;
  mag_t             drag_r, spin_drag_r, inv_mass_r, inv_inert_r;
  word_t            pos_r [3];
  word_t            vel_r [3];
  logic             out_valid_r;
  logic [191:0]     out_data_r;

  uop_t   uop;
  word_t  pos_cur, vel_cur;
  mag_t   vel_mag, op_a, op_b, prod;
  logic   add_neg;
  word_t  add_old, add_sum;
  logic   in_fire, out_load;
  mode_t  in_mode;

  assign uop      = uop_at(seq_r);
  assign pos_cur  = pos_r[uop.axis];
  assign vel_cur  = vel_r[uop.axis];
  assign vel_mag  = vel_cur[WORD_W-1] ? mag_t'(-vel_cur) : mag_t'(vel_cur);
  assign in_mode  = mode_t'(in_tuser);
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire  = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    op_a = (uop.asel == ASEL_TMP) ? tmp_r : vel_mag;
    case (uop.bsel)
      BSEL_VEL:  op_b = vel_mag;
      BSEL_COEF: op_b = (uop.axis == AXIS_ROT) ? spin_drag_r : drag_r;
      BSEL_INV:  op_b = (uop.axis == AXIS_ROT) ? inv_inert_r : inv_mass_r;
      BSEL_DT:   op_b = {{(WORD_W-DT_W){1'b0}}, dt_r};
      default:   op_b = vel_mag;
    endcase
    if (uop.dst == DST_POS) begin
      add_old = pos_cur;
      add_neg = vel_cur[WORD_W-1];
    end else begin
      add_old = vel_cur;
      add_neg = !vel_cur[WORD_W-1] && (vel_cur != '0);
    end
  end

  pbdi_mul u_mul (
    .clk    (clk),
    .en     (state_r == ST_MUL),
    .op_a   (op_a),
    .op_b   (op_b),
    .half   (uop.half),
    .prod_r (prod)
  );

  pbdi_sat_add u_add (
    .old_val (add_old),
    .neg     (add_neg),
    .mag     (prod),
    .sum     (add_sum)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_mode == MODE_STEP) ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL:  state_nxt = ST_WB;
      ST_WB:   state_nxt = (seq_r == SEQ_LAST) ? ST_DONE : ST_MUL;
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drag_r      <= '0;
      spin_drag_r <= '0;
      inv_mass_r  <= mag_t'(65536);
      inv_inert_r <= mag_t'(65536);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DRAG:      drag_r      <= cfg_data;
        CFG_SPIN_DRAG: spin_drag_r <= cfg_data;
        CFG_INV_MASS:  inv_mass_r  <= cfg_data;
        CFG_INV_INERT: inv_inert_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r[AXIS_X]   <= '0;
      pos_r[AXIS_Y]   <= '0;
      pos_r[AXIS_ROT] <= '0;
      vel_r[AXIS_X]   <= '0;
      vel_r[AXIS_Y]   <= '0;
      vel_r[AXIS_ROT] <= '0;
      seq_r <= '0;
    end else begin
      if (in_fire) begin
        seq_r <= '0;
        case (in_mode)
          MODE_LOAD_POS: begin
            pos_r[AXIS_X] <= in_tdata[47:16];
            pos_r[AXIS_Y] <= in_tdata[79:48];
          end
          MODE_LOAD_VEL: begin
            vel_r[AXIS_X] <= in_tdata[47:16];
            vel_r[AXIS_Y] <= in_tdata[79:48];
          end
          MODE_LOAD_ROT: begin
            pos_r[AXIS_ROT] <= in_tdata[47:16];
            vel_r[AXIS_ROT] <= in_tdata[79:48];
          end
          default: ;
        endcase
      end else if (state_r == ST_WB) begin
        seq_r <= seq_r + SEQ_W'(1);
        case (uop.dst)
          DST_POS: pos_r[uop.axis] <= add_sum;
          DST_VEL: vel_r[uop.axis] <= add_sum;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      dt_r <= in_tdata[15:0];
    end
    if (state_r == ST_WB && uop.dst == DST_TMP) begin
      tmp_r <= prod;
    end
    if (out_load) begin
      out_data_r <= {vel_r[AXIS_ROT], pos_r[AXIS_ROT], vel_r[AXIS_Y], vel_r[AXIS_X],
                     pos_r[AXIS_Y], pos_r[AXIS_X]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// File: sv/pbdi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbdi_checker
// Port-level checks for the planar body drag integrator, bound to the top.
// ----------------------------------------------------------------------------
module pbdi_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [79:0]  in_tdata,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [191:0] out_tdata
);
  import pbdi_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid set after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  a_load_pos_echo: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == MODE_LOAD_POS) && !out_tvalid
    |=> ##1 out_tvalid && (out_tdata[31:0] == $past(in_tdata[47:16], 2))
        && (out_tdata[63:32] == $past(in_tdata[79:48], 2)))
    else $error("loaded position not returned");

endmodule

bind planar_body_drag_integrator pbdi_checker u_pbdi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: bench/planar_body_drag_integrator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_body_drag_integrator_test
// Self-checking bench for the planar body integrator. A behavioral model of
// the Q16.16 midpoint update with quadratic and linear drag tracks the body
// state and the coefficient registers, and every output transaction is
// checked field by field against it. Directed limit cases come first, then
// random phases under several coefficient settings, with random idle cycles
// on both stream sides; some phases run without gaps on one or both sides.
// ----------------------------------------------------------------------------
module planar_body_drag_integrator_test;
  import pbdi_pkg::*;

  localparam int SETTLE_CYCLES  = 48;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 225;
  localparam int MAX_REPORTS    = 60;
  localparam logic [63:0] CAP   = 64'h0000_0000_8000_0000;

  // fields from the highest bits down, matching out_tdata
  typedef struct packed {
    word_t spin;
    word_t angle;
    word_t vel_y;
    word_t vel_x;
    word_t pos_y;
    word_t pos_x;
  } body_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [79:0]  in_tdata;   // dt[15:0], value_a[47:16], value_b[79:48]
  logic [1:0]   in_tuser;   // mode[1:0]
  logic         out_tvalid;
  logic         out_tready;
  logic [191:0] out_tdata;  // pos_x, pos_y, vel_x, vel_y, angle, spin
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;

  body_t       body;
  body_t       body_due[$];
  logic [31:0] drag_k;
  logic [31:0] spin_drag_k;
  logic [31:0] inv_mass_k;
  logic [31:0] inv_inertia_k;
  int          errors;
  int          quiet_cycles;
  int          src_gap_max;
  int          sink_gap_max;

  planar_body_drag_integrator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---- body model ----
  function automatic logic [63:0] magnitude(word_t v);
    logic [63:0] m;
    m = {32'd0, v};
    if (v[31]) m = 64'h1_0000_0000 - m;
    return m;
  endfunction

  function automatic logic [63:0] scaled(logic [63:0] a, logic [63:0] b, int sh);
    logic [63:0] p;
    p = (a * b) >> sh;
    return (p > CAP) ? CAP : p;
  endfunction

  function automatic word_t sat_add(word_t old, logic neg, logic [63:0] m);
    longint s;
    s = longint'(old) + (neg ? -longint'(m) : longint'(m));
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return word_t'(s);
  endfunction

  function automatic word_t half_drift(word_t p, word_t v, logic [15:0] dt);
    return sat_add(p, v[31], scaled(magnitude(v), {48'd0, dt}, 17));
  endfunction

  function automatic word_t kick(word_t v, logic [63:0] acc, logic [15:0] dt);
    return sat_add(v, v > 0, scaled(acc, {48'd0, dt}, 16));
  endfunction

  function automatic logic [63:0] quad_drag_accel(word_t v);
    logic [63:0] m;
    logic [63:0] sq;
    logic [63:0] f;
    m  = magnitude(v);
    sq = scaled(m, m, 16);
    f  = scaled(sq, {32'd0, drag_k}, 16);
    return scaled(f, {32'd0, inv_mass_k}, 16);
  endfunction

  task automatic integrate_body(mode_t mode, logic [15:0] dt, word_t a, word_t b);
    logic [63:0] acc;
    case (mode)
      MODE_STEP: begin
        acc        = quad_drag_accel(body.vel_x);
        body.pos_x = half_drift(body.pos_x, body.vel_x, dt);
        body.vel_x = kick(body.vel_x, acc, dt);
        body.pos_x = half_drift(body.pos_x, body.vel_x, dt);
        acc        = quad_drag_accel(body.vel_y);
        body.pos_y = half_drift(body.pos_y, body.vel_y, dt);
        body.vel_y = kick(body.vel_y, acc, dt);
        body.pos_y = half_drift(body.pos_y, body.vel_y, dt);
        acc        = scaled(scaled(magnitude(body.spin), {32'd0, spin_drag_k}, 16),
                            {32'd0, inv_inertia_k}, 16);
        body.angle = half_drift(body.angle, body.spin, dt);
        body.spin  = kick(body.spin, acc, dt);
        body.angle = half_drift(body.angle, body.spin, dt);
      end
      MODE_LOAD_POS: begin
        body.pos_x = a;
        body.pos_y = b;
      end
      MODE_LOAD_VEL: begin
        body.vel_x = a;
        body.vel_y = b;
      end
      default: begin
        body.angle = a;
        body.spin  = b;
      end
    endcase
    body_due.push_back(body);
  endtask

  // ---- reporting and checking ----
  task automatic report(string msg);
    if (errors < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string name, word_t got, word_t want);
    if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
  endtask

  always @(posedge clk) begin
    body_t got;
    body_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (body_due.size() == 0) begin
        report($sformatf("unexpected result %h", out_tdata));
      end else begin
        want = body_due.pop_front();
        check_field("pos_x", got.pos_x, want.pos_x);
        check_field("pos_y", got.pos_y, want.pos_y);
        check_field("vel_x", got.vel_x, want.vel_x);
        check_field("vel_y", got.vel_y, want.vel_y);
        check_field("angle", got.angle, want.angle);
        check_field("spin", got.spin, want.spin);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---- result sink ----
  initial begin
    int stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, sink_gap_max);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // ---- drivers ----
  task automatic send_item(mode_t mode, logic [15:0] dt, word_t a, word_t b);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {b, a, dt};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    integrate_body(mode, dt, a, b);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (body_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DRAG:      drag_k        = value;
      CFG_SPIN_DRAG: spin_drag_k   = value;
      CFG_INV_MASS:  inv_mass_k    = value;
      default:       inv_inertia_k = value;
    endcase
  endtask

  task automatic configure(logic [31:0] drag, logic [31:0] spin_drag,
                           logic [31:0] inv_mass, logic [31:0] inv_inertia);
    drain_results();
    write_reg(CFG_DRAG, drag);
    write_reg(CFG_SPIN_DRAG, spin_drag);
    write_reg(CFG_INV_MASS, inv_mass);
    write_reg(CFG_INV_INERT, inv_inertia);
    cfg_valid <= 1'b0;
  endtask

  // ---- random content ----
  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0, 1: return word_t'($urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
      2, 3: return word_t'($urandom_range(0, 32'h0200_0000) - 32'h0100_0000);
      4:    return word_t'($urandom);
      5: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      6:       return word_t'($urandom_range(0, 32) - 16);
      default: return word_t'($urandom_range(0, 32'h2000_0000) - 32'h1000_0000);
    endcase
  endfunction

  function automatic logic [15:0] rand_dt();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 2047));
      1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 32'h0002_0000);
      3:       return $urandom_range(0, 32'h0000_1000);
      4:       return $urandom;
      default: return 32'h0001_0000;
    endcase
  endfunction

  task automatic send_random_item();
    mode_t mode;
    case ($urandom_range(0, 9))
      6:       mode = MODE_LOAD_POS;
      7:       mode = MODE_LOAD_VEL;
      8:       mode = MODE_LOAD_ROT;
      9:       mode = mode_t'($urandom_range(0, 3));
      default: mode = MODE_STEP;
    endcase
    send_item(mode, rand_dt(), rand_word(), rand_word());
  endtask

  // ---- tests ----
  task automatic test_loads_and_limits();
    send_item(MODE_STEP, 16'hFFFF, 32'h0, 32'h0);
    send_item(MODE_LOAD_POS, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(MODE_LOAD_VEL, 16'h1234, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(MODE_LOAD_ROT, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(MODE_STEP, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(MODE_STEP, 16'h0000, 32'h0, 32'h0);
    send_item(MODE_LOAD_POS, 16'h0000, 32'h0, 32'h0);
    send_item(MODE_LOAD_ROT, 16'h0000, 32'h0, 32'h7FFF_FFFF);
    send_item(MODE_STEP, 16'h8000, 32'h0, 32'h0);
  endtask

  task automatic test_drag_extremes();
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(MODE_LOAD_VEL, 16'h0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(MODE_LOAD_ROT, 16'h0, 32'h0, 32'h8000_0000);
    send_item(MODE_STEP, 16'hFFFF, 32'h0, 32'h0);
    send_item(MODE_STEP, 16'h0001, 32'h0, 32'h0);
    // zero reciprocal mass and inertia: no deceleration at all
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_item(MODE_STEP, 16'hFFFF, 32'h0, 32'h0);
    configure(32'h0001_0000, 32'h0000_8000, 32'h0001_0000, 32'h0002_0000);
    send_item(MODE_LOAD_VEL, 16'h0, 32'h0003_0000, -32'sh0005_0000);
    send_item(MODE_LOAD_ROT, 16'h0, 32'h0, 32'h0002_0000);
    send_item(MODE_LOAD_POS, 16'h0, 32'h0, 32'h0);
    send_item(MODE_STEP, 16'h1000, 32'h0, 32'h0);
    send_item(MODE_STEP, 16'h4000, 32'h0, 32'h0);
    send_item(MODE_STEP, 16'h0001, 32'h0, 32'h0);
    send_item(MODE_LOAD_VEL, 16'h0, 32'h0000_0001, 32'hFFFF_FFFF);
    send_item(MODE_STEP, 16'hFFFF, 32'h0, 32'h0);
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       configure(32'h0, 32'h0, 32'h0, 32'h0);
        1:       configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        default: configure(rand_coef(), rand_coef(), rand_coef(), rand_coef());
      endcase
      src_gap_max  = (phase == 2 || phase == 5) ? 0 : 4;
      sink_gap_max = (phase == 2 || phase == 6) ? 0 : 4;
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_item();
    end
    src_gap_max  = 4;
    sink_gap_max = 4;
  endtask

  // after every eighth item the sender holds off until the result pipeline is empty
  task automatic test_drain_pause();
    configure(32'h0000_4000, 32'h0001_0000, 32'h0001_8000, 32'h0000_C000);
    for (int n = 0; n < 80; n++) begin
      send_random_item();
      if (n % 8 == 7) drain_results();
    end
  endtask

  initial begin
    errors        = 0;
    quiet_cycles  = 0;
    src_gap_max   = 4;
    sink_gap_max  = 4;
    body          = '0;
    drag_k        = 32'h0;
    spin_drag_k   = 32'h0;
    inv_mass_k    = 32'h0001_0000;
    inv_inertia_k = 32'h0001_0000;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= MODE_STEP;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_DRAG;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_loads_and_limits();
    test_drag_extremes();
    test_random_phases();
    test_drain_pause();
    drain_results();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
